@@ hw/rtl/ckc_pkg.sv @@
// Shared types and constants for the chroma key compositor.
// Word layouts of both channels, register indexes and conversion coefficients.
// No dependencies.
package ckc_pkg;

    // Input word: foreground pixel, background pixel, band select
    typedef struct packed {
        logic [7:0] front_red;
        logic [7:0] front_green;
        logic [7:0] front_blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic       band;
    } t_in_word;

    // Output word: composited pixel and key flag
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       keyed;
    } t_out_word;

    // Key averages of one band, unsigned 8.4 fixed point
    typedef struct packed {
        logic [11:0] luma;
        logic [11:0] blue_diff;
        logic [11:0] red_diff;
    } t_band_avg;

    // Full key setup handed from the register file to the keyer
    typedef struct packed {
        t_band_avg [1:0] band;
        logic [7:0]      tol;
    } t_key_cfg;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_LUMA0     = 3'd0,
        REG_BLUE0     = 3'd1,
        REG_RED0      = 3'd2,
        REG_LUMA1     = 3'd3,
        REG_BLUE1     = 3'd4,
        REG_RED1      = 3'd5,
        REG_TOL       = 3'd6
    } t_reg_idx;

    localparam int ADDR_W = 5;
    localparam int NUM_W  = 22;

    // Conversion numerators after the mid stage, plus the carried pixels
    typedef struct packed {
        logic [NUM_W-1:0] y_num;
        logic [NUM_W-1:0] cb_num;
        logic [NUM_W-1:0] cr_num;
        t_in_word         pix;
    } t_num_word;

    // BT.601 coefficients scaled by 10000, except CR_B (718, where BT.601 has 710)
    localparam logic [NUM_W:0] Y_R  = 23'd2570;
    localparam logic [NUM_W:0] Y_G  = 23'd5040;
    localparam logic [NUM_W:0] Y_B  = 23'd980;
    localparam logic [NUM_W:0] Y_OF = 23'd160000;
    localparam logic [NUM_W:0] CB_R = 23'd1480;
    localparam logic [NUM_W:0] CB_G = 23'd2910;
    localparam logic [NUM_W:0] CB_B = 23'd4390;
    localparam logic [NUM_W:0] C_OF = 23'd1280000;
    localparam logic [NUM_W:0] CR_R = 23'd4390;
    localparam logic [NUM_W:0] CR_G = 23'd3680;
    localparam logic [NUM_W:0] CR_B = 23'd718;

    // floor(n / 10000) = (n * RECIP_10K) >> RECIP_SH, exact for n < 2^22
    localparam logic [22:0] RECIP_10K = 23'd6871948;
    localparam int          RECIP_SH  = 36;
    localparam int          PROD_W    = NUM_W + 23;

    localparam logic [9:0] SUM_MIN = 10'd320;

endpackage

@@ hw/rtl/ckc_cfg.sv @@
// APB register file for the chroma key compositor: band averages and tolerance.
// Depends on ckc_pkg for the register indexes and the t_key_cfg layout.
module ckc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ckc_pkg::t_key_cfg           o_cfg
);
    import ckc_pkg::*;

    t_key_cfg r_cfg;
    t_key_cfg n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Decode the write; unknown indexes drop the word
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_LUMA0: n_cfg.band[0].luma      = pwdata[11:0];
                REG_BLUE0: n_cfg.band[0].blue_diff = pwdata[11:0];
                REG_RED0:  n_cfg.band[0].red_diff  = pwdata[11:0];
                REG_LUMA1: n_cfg.band[1].luma      = pwdata[11:0];
                REG_BLUE1: n_cfg.band[1].blue_diff = pwdata[11:0];
                REG_RED1:  n_cfg.band[1].red_diff  = pwdata[11:0];
                REG_TOL:   n_cfg.tol               = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back the selected register
    always_comb begin
        case (idx)
            REG_LUMA0: prdata = {20'd0, r_cfg.band[0].luma};
            REG_BLUE0: prdata = {20'd0, r_cfg.band[0].blue_diff};
            REG_RED0:  prdata = {20'd0, r_cfg.band[0].red_diff};
            REG_LUMA1: prdata = {20'd0, r_cfg.band[1].luma};
            REG_BLUE1: prdata = {20'd0, r_cfg.band[1].blue_diff};
            REG_RED1:  prdata = {20'd0, r_cfg.band[1].red_diff};
            REG_TOL:   prdata = {24'd0, r_cfg.tol};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/ckc_keyer.sv @@
// Key decision: divides the YCbCr numerators by 10000, tests them against the
// band averages and picks the background or foreground pixel. Uses ckc_pkg.
module ckc_keyer (
    input  ckc_pkg::t_num_word i_num,
    input  ckc_pkg::t_key_cfg  i_cfg,
    output ckc_pkg::t_out_word o_word
);
    import ckc_pkg::*;

    // Reciprocal multiply in place of a divide by 10000
    function automatic logic [7:0] div10k(input logic [NUM_W-1:0] n);
        logic [PROD_W-1:0] prod;
        prod = {23'd0, n} * {{(PROD_W-23){1'b0}}, RECIP_10K};
        return prod[RECIP_SH+7:RECIP_SH];
    endfunction

    function automatic logic [11:0] absdiff(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_band_avg   avg;
    logic [7:0]  yv;
    logic [7:0]  cbv;
    logic [7:0]  crv;
    logic [9:0]  sum;
    logic [11:0] dy;
    logic [11:0] dcb;
    logic [11:0] dcr;
    logic [14:0] dcr5;
    logic [14:0] lim3;
    logic [14:0] lim08;
    logic        hit;

    assign avg = i_cfg.band[i_num.pix.band];
    assign yv  = div10k(i_num.y_num);
    assign cbv = div10k(i_num.cb_num);
    assign crv = div10k(i_num.cr_num);

    // Bright enough and close to the key color on all three channels
    always_comb begin
        sum   = 10'(yv) + 10'(cbv) + 10'(crv);
        dy    = absdiff({yv, 4'd0}, avg.luma);
        dcb   = absdiff({cbv, 4'd0}, avg.blue_diff);
        dcr   = absdiff({crv, 4'd0}, avg.red_diff);
        dcr5  = 15'({dcr, 2'b00}) + 15'(dcr);
        lim3  = 15'({i_cfg.tol, 5'd0}) + 15'({i_cfg.tol, 4'd0});
        lim08 = 15'({i_cfg.tol, 6'd0});
        hit   = (sum > SUM_MIN) && (15'(dy) < lim3) && (15'(dcb) < lim3)
                && (dcr5 < lim08);
    end

    // Pass the background on a key hit, else the foreground
    always_comb begin
        o_word.keyed = hit;
        if (hit) begin
            o_word.out_red   = i_num.pix.back_red;
            o_word.out_green = i_num.pix.back_green;
            o_word.out_blue  = i_num.pix.back_blue;
        end else begin
            o_word.out_red   = i_num.pix.front_red;
            o_word.out_green = i_num.pix.front_green;
            o_word.out_blue  = i_num.pix.front_blue;
        end
    end

endmodule

@@ hw/rtl/chroma_key_compositor.sv @@
// Chroma key compositor top level: input register, numerator stage, keyer and
// result register. Depends on ckc_pkg, ckc_cfg and ckc_keyer.
//
//   channel   direction  handshake                   word
//   in        input      i_in_valid / o_in_stall     ckc_pkg::t_in_word
//   out       output     o_out_valid / i_out_stall   ckc_pkg::t_out_word
//   config    input      APB psel/penable/pwrite     7 registers at 4*i
//
// Three register stages: input, mid and result. One word per cycle while
// i_out_stall is low, since then every stage advances; one multiply level
// lies between registers (coefficients, then reciprocal).
// Synchronous active-low reset empties the pipe and clears the config registers; stage payloads are not reset.
// i_out_stall holds the result register; a full stage ahead of it backs up
// toward o_in_stall without losing or repeating a word.
module chroma_key_compositor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ckc_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ckc_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ckc_pkg::*;

    t_key_cfg  cfg;
    t_in_word  r_in_word;
    t_num_word r_mid_word;
    t_num_word n_mid_word;
    t_out_word r_out_word;
    t_out_word n_out_word;
    logic      r_in_valid;
    logic      r_mid_valid;
    logic      r_out_valid;
    logic      ld_in;
    logic      ld_mid;
    logic      ld_out;

    ckc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Advance a stage when it is empty or its word moves on
    assign ld_out     = !r_out_valid || !i_out_stall;
    assign ld_mid     = !r_mid_valid || ld_out;
    assign ld_in      = !r_in_valid || ld_mid;
    assign o_in_stall = !ld_in;

    // Form the three conversion numerators; all stay positive below 2^22
    always_comb begin
        n_mid_word.pix    = r_in_word;
        n_mid_word.y_num  = NUM_W'(Y_R * r_in_word.front_red + Y_G * r_in_word.front_green
                                  + Y_B * r_in_word.front_blue + Y_OF);
        n_mid_word.cb_num = NUM_W'(CB_B * r_in_word.front_blue + C_OF
                                  - CB_R * r_in_word.front_red
                                  - CB_G * r_in_word.front_green);
        n_mid_word.cr_num = NUM_W'(CR_R * r_in_word.front_red + C_OF
                                  - CR_G * r_in_word.front_green
                                  - CR_B * r_in_word.front_blue);
    end

    ckc_keyer u_keyer (
        .i_num  (r_mid_word),
        .i_cfg  (cfg),
        .o_word (n_out_word)
    );

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld_in) begin
                r_in_valid <= i_in_valid;
            end
            if (ld_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (ld_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (ld_in) begin
            r_in_word <= i_in_word;
        end
        if (ld_mid) begin
            r_mid_word <= n_mid_word;
        end
        if (ld_out) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // An accepted word lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_in_valid)
        else $error("accepted word not captured");

    // Input backs up only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_mid_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipe");

    // A held mid word is not dropped
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && !ld_out |=> r_mid_valid)
        else $error("mid stage word lost");
`endif

endmodule
